[hw/rtl/tlf_pkg.sv]
// tlf_pkg: shared types, character and register codes, and the microcode rom
// of the text line folder sequencer
// no dependencies
`default_nettype none

package tlf_pkg;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // configuration register indexes
  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_TAB_SIZE   = 2'd1;
  localparam logic [1:0] REG_FILL_CHAR  = 2'd2;

  // configuration reset values and limits
  localparam logic [5:0] LINE_WIDTH_RST = 6'd10;
  localparam logic [3:0] TAB_SIZE_RST   = 4'd4;
  localparam logic [3:0] TAB_SIZE_MAX   = 4'd8;
  localparam logic [7:0] FILL_CHAR_RST  = 8'd32;

  localparam int UA_W = 5;
  typedef logic [UA_W-1:0] uaddr_t;

  // micro-operations of the datapath
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FCHK,     // newline ahead of a word that overflows a non-empty line
    UOP_FBYTE,    // emit buffered word bytes, loops until the word is out
    UOP_SPACE,    // space, or newline at the line end
    UOP_NL,       // newline, column back to zero
    UOP_STORE,    // append the request byte to the word buffer
    UOP_SETSKIP,  // start swallowing spaces after a full word
    UOP_RSTLINE,  // end of stream: clear line state
    UOP_TABWRAP,  // newline when the line is full, start column remainder
    UOP_MOD,      // one restoring step of column mod tab size
    UOP_PADINIT,  // pad length = min(columns left, distance to tab stop)
    UOP_PAD       // emit fill bytes, loops over the pad length
  } uop_t;

  // jump conditions
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_SHORT     // word still shorter than the line after the store
  } jmp_t;

  typedef struct packed {
    uop_t   op;
    jmp_t   jmp;
    uaddr_t target;
  } uword_t;

  // program entry points
  localparam uaddr_t A_EOS     = 5'd0;
  localparam uaddr_t A_SPC     = 5'd3;
  localparam uaddr_t A_NL      = 5'd6;
  localparam uaddr_t A_TAB     = 5'd9;
  localparam uaddr_t A_TABONLY = 5'd11;
  localparam uaddr_t A_SKNL    = 5'd15;
  localparam uaddr_t A_SKCH    = 5'd16;
  localparam uaddr_t A_WORD    = 5'd17;
  localparam uaddr_t A_END     = 5'd21;

  typedef struct packed {
    logic [5:0] line_width;
    logic [3:0] tab_size;
    logic [7:0] fill_char;
  } cfg_t;

  // byte handed from the sequencer to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
    logic       last;
  } push_t;

  function automatic uword_t uw(input uop_t op, input jmp_t jmp, input uaddr_t tgt);
    uword_t w;
    w.op     = op;
    w.jmp    = jmp;
    w.target = tgt;
    return w;
  endfunction

  // microcode rom
  function automatic uword_t ucode(input uaddr_t a);
    uword_t w;
    unique case (a)
      // end of stream
      5'd0:  w = uw(UOP_FCHK,    JMP_NEXT,   A_END);
      5'd1:  w = uw(UOP_FBYTE,   JMP_NEXT,   A_END);
      5'd2:  w = uw(UOP_RSTLINE, JMP_ALWAYS, A_END);
      // space after a word
      5'd3:  w = uw(UOP_FCHK,    JMP_NEXT,   A_END);
      5'd4:  w = uw(UOP_FBYTE,   JMP_NEXT,   A_END);
      5'd5:  w = uw(UOP_SPACE,   JMP_ALWAYS, A_END);
      // newline after a word
      5'd6:  w = uw(UOP_FCHK,    JMP_NEXT,   A_END);
      5'd7:  w = uw(UOP_FBYTE,   JMP_NEXT,   A_END);
      5'd8:  w = uw(UOP_NL,      JMP_ALWAYS, A_END);
      // tab after a word, falls into the tab body
      5'd9:  w = uw(UOP_FCHK,    JMP_NEXT,   A_END);
      5'd10: w = uw(UOP_FBYTE,   JMP_NEXT,   A_END);
      5'd11: w = uw(UOP_TABWRAP, JMP_NEXT,   A_END);
      5'd12: w = uw(UOP_MOD,     JMP_NEXT,   A_END);
      5'd13: w = uw(UOP_PADINIT, JMP_NEXT,   A_END);
      5'd14: w = uw(UOP_PAD,     JMP_ALWAYS, A_END);
      // newline after swallowed spaces
      5'd15: w = uw(UOP_NL,      JMP_ALWAYS, A_END);
      // other byte after swallowed spaces: separator, then the word body
      5'd16: w = uw(UOP_SPACE,   JMP_NEXT,   A_END);
      // word byte
      5'd17: w = uw(UOP_STORE,   JMP_SHORT,  A_END);
      5'd18: w = uw(UOP_FCHK,    JMP_NEXT,   A_END);
      5'd19: w = uw(UOP_FBYTE,   JMP_NEXT,   A_END);
      5'd20: w = uw(UOP_SETSKIP, JMP_NEXT,   A_END);
      default: w = uw(UOP_NOP,   JMP_ALWAYS, A_END);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tlf_seq.sv]
// tlf_seq: microcoded sequencer and datapath of the text line folder
// uses tlf_pkg for the microcode rom, codes and interface structs
`default_nettype none

module tlf_seq #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tlf_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_eos,
  input  wire logic          out_free,
  output tlf_pkg::push_t     push
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = CW + 4;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  tlf_pkg::uaddr_t  pc_r, pc_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    wl_r, wl_nxt;
  logic             skip_r, skip_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [7:0]       pend_chr_r, pend_chr_nxt;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [MAX_WIDTH];

  tlf_pkg::uword_t  uw;
  logic [CW-1:0]    w_eff;
  logic [3:0]       ts_eff;
  logic             accept, entry_go, skip_clr;
  tlf_pkg::uaddr_t  entry;
  logic             fchk_nl, col_full, byte_left, store_short, rem_ge;
  logic [CW-1:0]    wl_after;
  logic [SW-1:0]    rem_sh, stop_w, left_w;
  logic [CW-1:0]    pad_len;
  logic             need_emit, loop_hold, stall, do_step, jump_taken;
  logic [7:0]       emit_chr;
  tlf_pkg::uaddr_t  next_addr;
  logic             mem_we;
  logic [AW-1:0]    rd_addr;

  assign uw = tlf_pkg::ucode(pc_r);

  // clamp the configured line width and tab size
  always_comb begin
    if (cfg.line_width == 6'd0) begin
      w_eff = CW'(1);
    end else if (cfg.line_width > 6'(MAX_WIDTH)) begin
      w_eff = MAXW;
    end else begin
      w_eff = cfg.line_width[CW-1:0];
    end
    if (cfg.tab_size == 4'd0) begin
      ts_eff = 4'd1;
    end else if (cfg.tab_size > tlf_pkg::TAB_SIZE_MAX) begin
      ts_eff = tlf_pkg::TAB_SIZE_MAX;
    end else begin
      ts_eff = cfg.tab_size;
    end
  end

  // request dispatch to a program entry
  assign in_ready = (state_r == ST_IDLE) && !pend_vld_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    entry    = tlf_pkg::A_WORD;
    entry_go = 1'b1;
    skip_clr = 1'b0;
    if (in_eos) begin
      entry = tlf_pkg::A_EOS;
    end else if (skip_r) begin
      skip_clr = (in_char != tlf_pkg::CH_SPACE);
      if (in_char == tlf_pkg::CH_SPACE) begin
        entry_go = 1'b0;
      end else if (in_char == tlf_pkg::CH_NL) begin
        entry = tlf_pkg::A_SKNL;
      end else if (in_char == tlf_pkg::CH_TAB) begin
        entry = tlf_pkg::A_TABONLY;
      end else begin
        entry = tlf_pkg::A_SKCH;
      end
    end else if (in_char == tlf_pkg::CH_SPACE) begin
      entry = tlf_pkg::A_SPC;
    end else if (in_char == tlf_pkg::CH_NL) begin
      entry = tlf_pkg::A_NL;
    end else if (in_char == tlf_pkg::CH_TAB) begin
      entry = tlf_pkg::A_TAB;
    end
  end

  // datapath conditions
  assign fchk_nl     = (col_r != '0) &&
                       (({1'b0, col_r} + {1'b0, wl_r}) > {1'b0, w_eff});
  assign col_full    = (col_r >= w_eff);
  assign byte_left   = (cnt_r < wl_r);
  assign wl_after    = (wl_r < MAXW) ? wl_r + CW'(1) : wl_r;
  assign store_short = (wl_after < w_eff);

  // remainder step and pad length
  assign rem_sh  = SW'(ts_eff) << cnt_r;
  assign rem_ge  = (SW'(rem_r) >= rem_sh);
  assign stop_w  = SW'(ts_eff) - SW'(rem_r);
  assign left_w  = SW'(w_eff - col_r);
  assign pad_len = (left_w < stop_w) ? left_w[CW-1:0] : stop_w[CW-1:0];

  // per-step emission and loop control
  always_comb begin
    need_emit = 1'b0;
    emit_chr  = tlf_pkg::CH_NL;
    loop_hold = 1'b0;
    unique case (uw.op)
      tlf_pkg::UOP_FCHK: need_emit = fchk_nl;
      tlf_pkg::UOP_FBYTE: begin
        need_emit = byte_left;
        emit_chr  = rdata_r;
        loop_hold = byte_left;
      end
      tlf_pkg::UOP_SPACE: begin
        need_emit = 1'b1;
        emit_chr  = col_full ? tlf_pkg::CH_NL : tlf_pkg::CH_SPACE;
      end
      tlf_pkg::UOP_NL:      need_emit = 1'b1;
      tlf_pkg::UOP_TABWRAP: need_emit = col_full;
      tlf_pkg::UOP_MOD:     loop_hold = (cnt_r != '0);
      tlf_pkg::UOP_PAD: begin
        need_emit = 1'b1;
        emit_chr  = cfg.fill_char;
        loop_hold = (cnt_r != CW'(1));
      end
      default: ;
    endcase
  end

  assign stall   = (state_r == ST_RUN) && need_emit && pend_vld_r && !out_free;
  assign do_step = (state_r == ST_RUN) && !stall;

  // next address
  always_comb begin
    case (uw.jmp)
      tlf_pkg::JMP_ALWAYS: jump_taken = 1'b1;
      tlf_pkg::JMP_SHORT:  jump_taken = store_short;
      default:             jump_taken = 1'b0;
    endcase
    next_addr = jump_taken ? uw.target : tlf_pkg::uaddr_t'(pc_r + 1'b1);
  end

  // register next values
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    col_nxt      = col_r;
    wl_nxt       = wl_r;
    skip_nxt     = skip_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    char_nxt     = char_r;
    pend_vld_nxt = pend_vld_r;
    pend_chr_nxt = pend_chr_r;

    if (accept) begin
      char_nxt = in_char;
      if (skip_clr) begin
        skip_nxt = 1'b0;
      end
      if (entry_go) begin
        state_nxt = ST_RUN;
        pc_nxt    = entry;
      end
    end

    if (do_step) begin
      unique case (uw.op)
        tlf_pkg::UOP_FCHK: begin
          if (fchk_nl) begin
            col_nxt = '0;
          end
          cnt_nxt = '0;
        end
        tlf_pkg::UOP_FBYTE: begin
          if (byte_left) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            col_nxt = col_r + wl_r;
            wl_nxt  = '0;
          end
        end
        tlf_pkg::UOP_SPACE: col_nxt = col_full ? '0 : col_r + CW'(1);
        tlf_pkg::UOP_NL:    col_nxt = '0;
        tlf_pkg::UOP_STORE: wl_nxt = wl_after;
        tlf_pkg::UOP_SETSKIP: skip_nxt = 1'b1;
        tlf_pkg::UOP_RSTLINE: begin
          col_nxt  = '0;
          wl_nxt   = '0;
          skip_nxt = 1'b0;
        end
        tlf_pkg::UOP_TABWRAP: begin
          col_nxt = col_full ? '0 : col_r;
          rem_nxt = col_full ? '0 : col_r;
          cnt_nxt = CW'(CW - 1);
        end
        tlf_pkg::UOP_MOD: begin
          if (rem_ge) begin
            rem_nxt = rem_r - rem_sh[CW-1:0];
          end
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        tlf_pkg::UOP_PADINIT: cnt_nxt = pad_len;
        tlf_pkg::UOP_PAD: begin
          col_nxt = col_r + CW'(1);
          cnt_nxt = cnt_r - CW'(1);
        end
        default: ;
      endcase
      if (!loop_hold) begin
        pc_nxt = next_addr;
        if (next_addr == tlf_pkg::A_END) begin
          state_nxt = ST_IDLE;
        end
      end
    end

    // one byte held back so the last one of a request can be marked
    if (do_step && need_emit) begin
      pend_vld_nxt = 1'b1;
      pend_chr_nxt = emit_chr;
    end else if ((state_r == ST_IDLE) && pend_vld_r && out_free) begin
      pend_vld_nxt = 1'b0;
    end
  end

  // hand the held byte to the output register
  always_comb begin
    push.vld  = pend_vld_r &&
                ((do_step && need_emit) || ((state_r == ST_IDLE) && out_free));
    push.chr  = pend_chr_r;
    push.last = (state_r == ST_IDLE);
  end

  // word buffer
  assign mem_we  = do_step && (uw.op == tlf_pkg::UOP_STORE) && (wl_r < MAXW);
  assign rd_addr = cnt_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wl_r[AW-1:0]] <= char_r;
    end
    rdata_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pc_r       <= tlf_pkg::A_END;
      col_r      <= '0;
      wl_r       <= '0;
      skip_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      col_r      <= col_nxt;
      wl_r       <= wl_nxt;
      skip_r     <= skip_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    char_r     <= char_nxt;
    pend_chr_r <= pend_chr_nxt;
  end

  // column and word length stay within the buffer
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= MAXW)
    else $error("column beyond maximum width");

  a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r <= MAXW)
    else $error("word length beyond buffer");

  // swallowing spaces only ever follows a flushed word
  a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (wl_r == '0))
    else $error("space swallowing with a pending word");

endmodule

`default_nettype wire

[hw/rtl/text_line_folder_unit.sv]
// text_line_folder_unit: greedy word-wrap line folder top, config and output registers
// uses tlf_pkg, tlf_seq; each request runs a microcode program: a word byte is stored,
// a space or newline first flushes the buffered word byte by byte, a byte that completes
// a full word flushes it too; a tab adds a wrap check, clog2(MAX_WIDTH+1) remainder steps
// and the fill bytes; one request at a time, the sequencer pauses while the output is full
// synchronous reset clears line state and loads register defaults, word buffer kept
`default_nettype none

module text_line_folder_unit #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_stream,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);

  tlf_pkg::cfg_t  cfg_r;
  tlf_pkg::push_t push;
  logic           out_valid_r;
  logic [7:0]     out_char_r;
  logic           out_last_r;
  logic           out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width <= tlf_pkg::LINE_WIDTH_RST;
      cfg_r.tab_size   <= tlf_pkg::TAB_SIZE_RST;
      cfg_r.fill_char  <= tlf_pkg::FILL_CHAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tlf_pkg::REG_LINE_WIDTH: cfg_r.line_width <= cfg_wdata[5:0];
        tlf_pkg::REG_TAB_SIZE:   cfg_r.tab_size   <= cfg_wdata[3:0];
        tlf_pkg::REG_FILL_CHAR:  cfg_r.fill_char  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  tlf_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char_code),
    .in_eos   (in_end_of_stream),
    .out_free (out_free),
    .push     (push)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      out_char_r <= push.chr;
      out_last_r <= push.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // the sequencer never overwrites a byte still waiting at the output
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> out_free)
    else $error("byte pushed into a full output register");

  // no new request while bytes of the previous one are still held back
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !push.vld)
    else $error("request accepted during a push");

  // a marked last byte is never directly followed by a second marked last byte
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (push.vld && push.last) |=> !(push.vld && push.last))
    else $error("two request ends in consecutive cycles");

endmodule

`default_nettype wire

[bench/text_line_folder_unit_tb.sv]
// text_line_folder_unit_tb: self-checking bench for the greedy word-wrap line folder
// drives requests and register writes, predicts the folded byte stream, checks each byte
// depends on tlf_pkg and text_line_folder_unit
`timescale 1ns / 1ps

module text_line_folder_unit_tb;

  localparam int WORD_MAX     = 32;
  localparam int RESULT_CAP   = 42;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 53;

  // folding predictor plus the queue of bytes still owed by the block
  class fold_scoreboard;
    bit [7:0]    word_buf[WORD_MAX];
    int unsigned word_len;
    int unsigned col;
    bit          skipping;
    bit [5:0]    width_reg;
    bit [3:0]    tab_reg;
    bit [7:0]    fill_reg;
    bit [7:0]    item_bytes[$];
    bit [8:0]    owed_q[$];
    int          errors;

    function new();
      word_len  = 0;
      col       = 0;
      skipping  = 1'b0;
      width_reg = tlf_pkg::LINE_WIDTH_RST;
      tab_reg   = tlf_pkg::TAB_SIZE_RST;
      fill_reg  = tlf_pkg::FILL_CHAR_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        tlf_pkg::REG_LINE_WIDTH: width_reg = val[5:0];
        tlf_pkg::REG_TAB_SIZE:   tab_reg   = val[3:0];
        tlf_pkg::REG_FILL_CHAR:  fill_reg  = val;
        default: ;
      endcase
    endfunction

    function void put(bit [7:0] c);
      if (item_bytes.size() < RESULT_CAP) item_bytes.push_back(c);
    endfunction

    function void break_line();
      put(tlf_pkg::CH_NL);
      col = 0;
    endfunction

    // pending word, with a newline first when it overflows a non-empty line
    function void flush_word(int unsigned w);
      if (col > 0 && col + word_len > w) break_line();
      for (int unsigned i = 0; i < word_len; i++) put(word_buf[i]);
      col += word_len;
      word_len = 0;
    endfunction

    function void space_sep(int unsigned w);
      if (col < w) begin
        put(tlf_pkg::CH_SPACE);
        col++;
      end else begin
        break_line();
      end
    endfunction

    // pad to the next tab stop, never past the line end
    function void tab_pad(int unsigned w, int unsigned ts);
      int unsigned room, stop, pad;
      if (col >= w) break_line();
      room = w - col;
      stop = ts - (col % ts);
      pad  = (room < stop) ? room : stop;
      for (int unsigned i = 0; i < pad; i++) put(fill_reg);
      col += pad;
    endfunction

    function void add_char(bit [7:0] c, int unsigned w);
      if (word_len < WORD_MAX) begin
        word_buf[word_len] = c;
        word_len++;
      end
      if (word_len >= w) begin
        flush_word(w);
        skipping = 1'b1;
      end
    endfunction

    function void note_request(bit [7:0] c, bit eos);
      int unsigned w, ts, n;
      w  = width_reg;
      ts = tab_reg;
      if (w < 1) w = 1;
      if (w > WORD_MAX) w = WORD_MAX;
      if (ts < 1) ts = 1;
      if (ts > tlf_pkg::TAB_SIZE_MAX) ts = tlf_pkg::TAB_SIZE_MAX;
      item_bytes.delete();
      if (eos) begin
        flush_word(w);
        word_len = 0;
        col      = 0;
        skipping = 1'b0;
      end else if (skipping) begin
        if (c != tlf_pkg::CH_SPACE) begin
          skipping = 1'b0;
          if (c == tlf_pkg::CH_NL) begin
            break_line();
          end else if (c == tlf_pkg::CH_TAB) begin
            tab_pad(w, ts);
          end else begin
            space_sep(w);
            add_char(c, w);
          end
        end
      end else if (c == tlf_pkg::CH_SPACE) begin
        flush_word(w);
        space_sep(w);
      end else if (c == tlf_pkg::CH_NL) begin
        flush_word(w);
        break_line();
      end else if (c == tlf_pkg::CH_TAB) begin
        flush_word(w);
        tab_pad(w, ts);
      end else begin
        add_char(c, w);
      end
      n = item_bytes.size();
      for (int unsigned i = 0; i < n; i++) owed_q.push_back({item_bytes[i], i == n - 1});
    endfunction

    function void check_result(bit [7:0] ch, bit lst);
      bit [8:0] exp_b;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual char %02h last %0b",
                 $time, ch, lst);
        errors++;
        return;
      end
      exp_b = owed_q.pop_front();
      if (exp_b[8:1] !== ch) begin
        $display("%0t: out_char expected %02h actual %02h", $time, exp_b[8:1], ch);
        errors++;
      end
      if (exp_b[0] !== lst) begin
        $display("%0t: out_last expected %0b actual %0b", $time, exp_b[0], lst);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = tlf_pkg::REG_LINE_WIDTH;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'd0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last;

  fold_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    in_idle_mode = 0;
  int unsigned    out_idle_mode = 0;
  int unsigned    requests_sent = 0;
  bit             hold_request = 1'b0;

  text_line_folder_unit #(.MAX_WIDTH(WORD_MAX)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle cycles per request: none, full range, or mostly none
  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  task automatic send_request(input logic [7:0] c, input logic eos);
    int unsigned gap;
    gap = draw_gap(in_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_char_code     <= c;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, eos);
    requests_sent++;
    if (requests_sent % 40 == 0) in_idle_mode = $urandom_range(0, 2);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // wait until every owed byte is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [5:0] w, input logic [3:0] ts,
                              input logic [7:0] fill);
    logic [1:0] idx[3];
    logic [7:0] val[3];
    idx = '{tlf_pkg::REG_LINE_WIDTH, tlf_pkg::REG_TAB_SIZE, tlf_pkg::REG_FILL_CHAR};
    val = '{{2'b00, w}, {4'b0000, ts}, fill};
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'("a") + 8'($urandom_range(0, 25));
  endfunction

  // random text: mostly words and separators, some noise
  task automatic send_random_text(input int unsigned n_items, input int unsigned w_eff);
    int unsigned start, len, r, s;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w_eff + 3)
                                          : $urandom_range(1, 6);
        repeat (len) send_request(word_char(), 1'b0);
        s = $urandom_range(0, 99);
        if (s < 55) begin
          repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1)
            send_request(tlf_pkg::CH_SPACE, 1'b0);
        end else if (s < 70) begin
          send_request(tlf_pkg::CH_NL, 1'b0);
        end else if (s < 85) begin
          send_request(tlf_pkg::CH_TAB, 1'b0);
        end else if (s < 92) begin
          send_eos();
        end
      end else if (r < 85) begin
        send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 2))
          0: send_request(tlf_pkg::CH_SPACE, 1'b0);
          1: send_request(tlf_pkg::CH_NL, 1'b0);
          default: send_request(tlf_pkg::CH_TAB, 1'b0);
        endcase
      end
    end
  endtask

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        stall = 0;
      end else begin
        stall = draw_gap(out_idle_mode);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_char, out_last);
      taken++;
      if (taken % 32 == 0) out_idle_mode = $urandom_range(0, 2);
    end
  end

  // main sequence
  initial begin : stimulus
    logic [5:0]  w;
    logic [3:0]  ts;
    logic [7:0]  fill;
    int unsigned w_eff;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: tab after a word, spaces, newline, empty end of stream, byte extremes
    send_text("hi\t  \n");
    send_eos();
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_eos();
    settle();

    // narrow line: full word swallows spaces, next byte wraps, tab capped at line end
    write_config(6'd3, 4'd15, 8'h2E);
    send_text("abc  d\tef");
    settle();

    // width lowered below the pending word, zero tab size, skipping then eos
    write_config(6'd0, 4'd0, 8'h00);
    send_text("x\ny\tz");
    send_eos();
    settle();

    // random phases over several settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 6'd63; ts = 4'd15; fill = 8'hFF; end
        1: begin w = 6'd32; ts = 4'd8;  fill = 8'h00; end
        2: begin w = 6'd0;  ts = 4'd0;  fill = 8'($urandom_range(0, 255)); end
        3: begin w = 6'd1;  ts = 4'd1;  fill = 8'($urandom_range(0, 255)); end
        4: begin w = 6'd33; ts = 4'd9;  fill = 8'($urandom_range(0, 255)); end
        default: begin
          w    = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(2, 12))
                                             : 6'($urandom_range(0, 63));
          ts   = 4'($urandom_range(0, 15));
          fill = 8'($urandom_range(0, 255));
        end
      endcase
      write_config(w, ts, fill);
      w_eff = (w < 1) ? 1 : ((w > WORD_MAX) ? WORD_MAX : w);
      if (p == 2) hold_request = 1'b1;
      send_random_text(PHASE_ITEMS, w_eff);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tlf_pkg.sv
hw/rtl/tlf_seq.sv
hw/rtl/text_line_folder_unit.sv
bench/text_line_folder_unit_tb.sv
